@@ hdl/sis_pkg.sv @@
// Package for the sorted index set: sizes, word types, status codes,
// controller states and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package sis_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int INDEX_BITS  = 16;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Fixed result field widths
  localparam int POS_W      = 6;
  localparam int OUT_CNT_W  = 7;
  localparam int STATUS_W   = 2;

  // Item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic                  kind;
    logic [INDEX_BITS-1:0] index_value;
  } sis_in_t;

  typedef struct packed {
    logic                 found;
    logic [POS_W-1:0]     position;
    logic [OUT_CNT_W-1:0] entry_count;
    logic [STATUS_W-1:0]  status;
  } sis_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DECIDE,
    S_SHIFT_PRIME,
    S_SHIFT,
    S_INS_WR,
    S_RESP
  } sis_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;         // capture input word, restart scan
    logic scan_rd;      // read entry at scan pointer
    logic scan_adv;     // step scan pointer
    logic set_slot;     // slot found at scan pointer
    logic mark_hit;     // with set_slot: entry equals value
    logic drop;         // insert dropped, table full
    logic shift_prime;  // first read of the shift pass
    logic shift_step;   // move one entry up
    logic ins_wr;       // write value at slot, bump count
    logic emit;         // load output register
  } sis_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic at_end;       // scan pointer reached count
    logic lt;           // read entry below value
    logic hit;          // value present
    logic is_lookup;
    logic full;
    logic slot_at_end;  // slot equals count, nothing to move
    logic shift_last;   // this shift step fills slot + 1
    logic out_free;     // output register can take a word
  } sis_stat_t;

endpackage

@@ hdl/sis_ctrl.sv @@
// Controller for the sorted index set: sequences search, shift and insert.
// Depends on sis_pkg.
`timescale 1ns / 1ps

module sis_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sis_pkg::sis_stat_t stat,
  output sis_pkg::sis_cmd_t  cmd
);
  import sis_pkg::*;

  sis_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SRCH_RD;
      end
      S_SRCH_RD: begin
        state_nxt = stat.at_end ? S_DECIDE : S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        state_nxt = stat.lt ? S_SRCH_RD : S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.hit || stat.is_lookup || stat.full) state_nxt = S_RESP;
        else if (stat.slot_at_end)                   state_nxt = S_INS_WR;
        else                                         state_nxt = S_SHIFT_PRIME;
      end
      S_SHIFT_PRIME: begin
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        if (stat.shift_last) state_nxt = S_INS_WR;
      end
      S_INS_WR: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SRCH_RD: begin
        cmd.scan_rd  = !stat.at_end;
        cmd.set_slot = stat.at_end;
      end
      S_SRCH_CMP: begin
        cmd.scan_adv = stat.lt;
        cmd.set_slot = !stat.lt;
        cmd.mark_hit = !stat.lt;
      end
      S_DECIDE: begin
        cmd.drop = !stat.hit && !stat.is_lookup && stat.full;
      end
      S_SHIFT_PRIME: begin
        cmd.shift_prime = 1'b1;
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
      end
      S_INS_WR: begin
        cmd.ins_wr = 1'b1;
      end
      S_RESP: begin
        cmd.emit = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

@@ hdl/sis_dp.sv @@
// Datapath for the sorted index set: entry memory, scan/shift pointer,
// count, result flags and the output register. Depends on sis_pkg.
`timescale 1ns / 1ps

module sis_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  sis_pkg::sis_in_t   in_data,
  input  sis_pkg::sis_cmd_t  cmd,
  output sis_pkg::sis_stat_t stat,
  output logic               out_valid,
  input  logic               out_ready,
  output sis_pkg::sis_out_t  out_data
);
  import sis_pkg::*;

  logic [INDEX_BITS-1:0] entries_r [TABLE_DEPTH];
  logic [INDEX_BITS-1:0] rdata_r;

  logic [INDEX_BITS-1:0] value_r;
  logic                  kind_r;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]      slot_r;
  logic                  hit_r;
  logic                  drop_r;
  logic                  out_valid_r;
  sis_out_t              out_word_r, out_word_nxt;

  logic [CNT_W-1:0]      cnt_m1, idx_m2, slot_p1;
  logic                  mem_we, mem_re;
  logic [ADDR_W-1:0]     wr_addr, rd_addr;
  logic [INDEX_BITS-1:0] wr_data;
  logic                  inserted;

  assign cnt_m1  = count_r - CNT_W'(1);
  assign idx_m2  = idx_r - CNT_W'(2);
  assign slot_p1 = slot_r + CNT_W'(1);

  // Memory port selection
  always_comb begin
    mem_re  = cmd.scan_rd || cmd.shift_prime || cmd.shift_step;
    rd_addr = idx_r[ADDR_W-1:0];
    if (cmd.shift_prime)     rd_addr = cnt_m1[ADDR_W-1:0];
    else if (cmd.shift_step) rd_addr = idx_m2[ADDR_W-1:0];
    mem_we  = cmd.shift_step || cmd.ins_wr;
    wr_addr = cmd.ins_wr ? slot_r[ADDR_W-1:0] : idx_r[ADDR_W-1:0];
    wr_data = cmd.ins_wr ? value_r : rdata_r;
  end

  // Entry memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) entries_r[wr_addr] <= wr_data;
    if (mem_re) rdata_r <= entries_r[rd_addr];
  end

  // Scan / shift pointer
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load)             idx_nxt = '0;
    else if (cmd.scan_adv)    idx_nxt = idx_r + CNT_W'(1);
    else if (cmd.shift_prime) idx_nxt = count_r;
    else if (cmd.shift_step)  idx_nxt = idx_r - CNT_W'(1);
  end

  // Item payload and search results
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load) begin
      value_r <= in_data.index_value;
      kind_r  <= in_data.kind;
      drop_r  <= 1'b0;
    end
    if (cmd.set_slot) begin
      slot_r <= idx_r;
      hit_r  <= cmd.mark_hit && (rdata_r == value_r);
    end
    if (cmd.drop) drop_r <= 1'b1;
    if (cmd.emit) out_word_r <= out_word_nxt;
  end

  // Control state: count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.ins_wr) count_r <= count_r + CNT_W'(1);
      if (cmd.emit)         out_valid_r <= 1'b1;
      else if (out_ready)   out_valid_r <= 1'b0;
    end
  end

  // Result word
  assign inserted = (kind_r == KIND_INSERT) && !hit_r && !drop_r;
  always_comb begin
    out_word_nxt.found       = hit_r;
    out_word_nxt.position    = (hit_r || inserted) ? POS_W'(slot_r) : '0;
    out_word_nxt.entry_count = OUT_CNT_W'(count_r);
    if (kind_r == KIND_INSERT && hit_r) out_word_nxt.status = ST_DUP;
    else if (drop_r)                    out_word_nxt.status = ST_FULL;
    else                                out_word_nxt.status = ST_OK;
  end

  // Status to the controller
  always_comb begin
    stat.at_end      = (idx_r == count_r);
    stat.lt          = (rdata_r < value_r);
    stat.hit         = hit_r;
    stat.is_lookup   = (kind_r == KIND_LOOKUP);
    stat.full        = (count_r == CNT_W'(TABLE_DEPTH));
    stat.slot_at_end = (slot_r == count_r);
    stat.shift_last  = (idx_r == slot_p1);
    stat.out_free    = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

@@ hdl/sorted_index_set.sv @@
// Sorted index set. The time an item takes grows with the number of stored
// entries it scans and moves; the single-port read of the entry memory in
// the scan and shift loops sets it.
// One item is in work at a time; a new word is taken while a result waits.
// Reset clears the count and the handshake state; entry memory is not
// cleared, as entries at or above the count are never read.
`timescale 1ns / 1ps

module sorted_index_set (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sis_pkg::sis_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sis_pkg::sis_out_t out_data
);
  import sis_pkg::*;

  sis_cmd_t  cmd;
  sis_stat_t stat;

  // Sequencer
  sis_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Memory, pointers and output register
  sis_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ hdl/sis_checker.sv @@
// Port-level checks for the sorted index set, bound to the top level.
// Depends on sis_pkg and sorted_index_set.
`timescale 1ns / 1ps

module sis_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input sis_pkg::sis_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input sis_pkg::sis_out_t out_data
);
  import sis_pkg::*;

  // A waiting input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input word changed while waiting");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.entry_count <= OUT_CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // A dropped insert reports a full table and no position
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |->
      !out_data.found && out_data.position == '0 &&
      out_data.entry_count == OUT_CNT_W'(TABLE_DEPTH))
    else $error("full-table result inconsistent");

  // A duplicate insert always reports found
  a_dup_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_DUP |-> out_data.found)
    else $error("duplicate status without found");

endmodule

bind sorted_index_set sis_checker u_sis_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ bench/tb_sorted_index_set.sv @@
// Testbench for sorted_index_set: drives insert and lookup words, predicts each
// result from a local copy of the sorted table and checks every result word.
// Depends on sis_pkg and the sorted_index_set RTL.
`timescale 1ns / 1ps

module tb_sorted_index_set;
  import sis_pkg::*;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  sis_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  sis_out_t out_data;

  // Predicted table contents and count
  logic [INDEX_BITS-1:0] stored_rows [TABLE_DEPTH];
  int                    row_count = 0;

  // Results still owed by the block, oldest first
  sis_out_t pending_results [$];
  int       mismatch_count = 0;

  // Idle control shared by sender and receiver
  bit idle_off     = 1'b0;
  int hold_request = 0;
  int hold_left    = 0;
  int stall_left   = 0;

  sorted_index_set dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 120);
  endfunction

  function automatic bit row_present(input logic [INDEX_BITS-1:0] v);
    for (int i = 0; i < row_count; i++)
      if (stored_rows[i] == v) return 1'b1;
    return 1'b0;
  endfunction

  // Random value not yet in the table
  function automatic logic [INDEX_BITS-1:0] fresh_value();
    logic [INDEX_BITS-1:0] v;
    v = INDEX_BITS'($urandom);
    while (row_present(v)) v = INDEX_BITS'($urandom);
    return v;
  endfunction

  // Random stored value, or any value while the table is empty
  function automatic logic [INDEX_BITS-1:0] stored_value();
    if (row_count == 0) return INDEX_BITS'($urandom);
    return stored_rows[$urandom_range(0, row_count - 1)];
  endfunction

  // Sorted insert / lookup: updates the local table and returns the result word
  function automatic sis_out_t apply_sorted_op(input logic kind,
                                               input logic [INDEX_BITS-1:0] v);
    sis_out_t res;
    int       slot;
    res  = '0;
    slot = 0;
    while (slot < row_count && stored_rows[slot] < v) slot++;
    res.status = ST_OK;
    if (slot < row_count && stored_rows[slot] == v) begin
      res.found    = 1'b1;
      res.position = slot[POS_W-1:0];
      if (kind == KIND_INSERT) res.status = ST_DUP;
    end else if (kind == KIND_INSERT) begin
      if (row_count >= TABLE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        for (int j = row_count; j > slot; j--) stored_rows[j] = stored_rows[j - 1];
        stored_rows[slot] = v;
        row_count++;
        res.position = slot[POS_W-1:0];
      end
    end
    res.entry_count = row_count[OUT_CNT_W-1:0];
    return res;
  endfunction

  // Send one word; the prediction is queued at the accepting edge
  task automatic send_word(input logic kind, input logic [INDEX_BITS-1:0] v);
    sis_in_t w;
    int      gap;
    w.kind        = kind;
    w.index_value = v;
    gap = idle_off ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_sorted_op(kind, v));
  endtask

  // Receiver: check accepted result words, then pick next out_ready
  always @(posedge clk) begin
    sis_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result word %p", $realtime, out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.found !== want.found || out_data.position !== want.position ||
            out_data.entry_count !== want.entry_count ||
            out_data.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result mismatch: expected %p, got %p",
                     $realtime, want, out_data);
        end
      end
    end
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!idle_off) stall_left = pick_gap();
    end
  end

  // Empty table, head / tail / middle inserts, duplicates, hits and misses
  task automatic test_directed();
    send_word(KIND_LOOKUP, 16'h1234);
    send_word(KIND_INSERT, 16'h8000);
    send_word(KIND_INSERT, 16'h8000);
    send_word(KIND_INSERT, 16'h0000);
    send_word(KIND_INSERT, 16'h0000);
    send_word(KIND_INSERT, 16'hFFFF);
    send_word(KIND_INSERT, 16'hFFFF);
    send_word(KIND_INSERT, 16'h7FFF);
    send_word(KIND_INSERT, 16'h5555);
    send_word(KIND_INSERT, 16'hAAAA);
    send_word(KIND_LOOKUP, 16'h0000);
    send_word(KIND_LOOKUP, 16'hFFFF);
    send_word(KIND_LOOKUP, 16'h7FFF);
    send_word(KIND_LOOKUP, 16'h0001);
    send_word(KIND_LOOKUP, 16'hFFFE);
    send_word(KIND_INSERT, 16'h8000);
    send_word(KIND_LOOKUP, 16'hAAAA);
  endtask

  // Receiver held off while the sender keeps offering words back to back
  task automatic test_output_backpressure();
    idle_off     = 1'b1;
    hold_request = 600;
    for (int i = 0; i < 20; i++) begin
      if (i % 3 == 0) send_word(KIND_LOOKUP, stored_value());
      else send_word(KIND_INSERT, fresh_value());
    end
    idle_off = 1'b0;
  endtask

  // Mixed traffic; the table fills gradually along the way
  task automatic test_random_mix(input int n_items);
    int r;
    logic [INDEX_BITS-1:0] v;
    for (int i = 0; i < n_items; i++) begin
      if (i % 150 == 0) idle_off = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 15) begin
        send_word(KIND_INSERT, fresh_value());
      end else if (r < 30) begin
        send_word(KIND_INSERT, stored_value());
      end else if (r < 58) begin
        send_word(KIND_LOOKUP, stored_value());
      end else if (r < 78) begin
        send_word(KIND_LOOKUP, INDEX_BITS'($urandom));
      end else if (r < 88) begin
        send_word(KIND_INSERT, INDEX_BITS'($urandom));
      end else begin
        // near misses around stored values
        v = stored_value();
        send_word(KIND_LOOKUP, $urandom_range(0, 1) ? v + 1'b1 : v - 1'b1);
      end
    end
    idle_off = 1'b0;
  endtask

  // Full table: new values dropped, duplicates still reported as duplicates
  task automatic test_full_table();
    while (row_count < TABLE_DEPTH) send_word(KIND_INSERT, fresh_value());
    send_word(KIND_INSERT, fresh_value());
    send_word(KIND_INSERT, 16'h0000);
    send_word(KIND_INSERT, 16'hFFFF);
    send_word(KIND_INSERT, stored_rows[0]);
    send_word(KIND_INSERT, stored_rows[TABLE_DEPTH - 1]);
    send_word(KIND_LOOKUP, stored_rows[0]);
    send_word(KIND_LOOKUP, stored_rows[TABLE_DEPTH - 1]);
    send_word(KIND_LOOKUP, fresh_value());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_output_backpressure();
    test_random_mix(1200);
    test_full_table();
    in_valid <= 1'b0;
    // drain, then watch for stray words
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3 * TABLE_DEPTH + 20) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
